>>> hdl/conv3_pkg.sv
// shared constants and types for the 3x3 convolution filter
`timescale 1ns / 1ps

package conv3_pkg;

  localparam int PIX_W       = 16;
  localparam int COEF_W      = 16;
  localparam int KSIZE       = 3;
  localparam int KROW_W      = KSIZE * COEF_W;
  localparam int PROD_W      = PIX_W + COEF_W;
  localparam int RSUM_W      = PROD_W + 2;
  localparam int FILT_W      = 35;
  localparam int ROW_W       = 12;
  localparam int OCOL_W      = 10;
  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 13;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

  localparam logic [KROW_W-1:0] KTOP_RST    = 48'h0000_FF00_0000;
  localparam logic [KROW_W-1:0] KMID_RST    = 48'hFF00_0400_FF00;
  localparam logic [KROW_W-1:0] KBOTTOM_RST = 48'h0000_FF00_0000;
  localparam int IMG_W_RST = 5;
  localparam int IMG_H_RST = 5;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [FILT_W-1:0] filt_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } pos_t;

endpackage

>>> hdl/conv3_in_if.sv
// pixel input channel
`timescale 1ns / 1ps

interface conv3_in_if import conv3_pkg::*;;
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

>>> hdl/conv3_out_if.sv
// filter result channel
`timescale 1ns / 1ps

interface conv3_out_if import conv3_pkg::*;;
  logic              valid;
  logic              ready;
  filt_t             filtered;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;
  logic              last;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input filtered, input out_row, input out_col,
                input last, output ready);
endinterface

>>> hdl/conv3x3_image_filter.sv
// 3x3 convolution filter over a raster pixel stream with two line buffers
// a window's last pixel passes stages a to d and the output register before its result is valid
// throughput: one pixel per cycle unless stalled; set by one read and write port per line buffer
// a stalled result is held in the output register plus one skid entry, then input stops
// reset: position counters, pipeline valids and config go to defaults; line buffers are not cleared
`timescale 1ns / 1ps

module conv3x3_image_filter import conv3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  conv3_in_if.sink              in_chan,
  conv3_out_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
  localparam int W_RST = (MAX_WIDTH < IMG_W_RST) ? MAX_WIDTH : IMG_W_RST;

  typedef struct packed {
    filt_t filtered;
    pos_t  pos;
  } res_t;

  // configuration
  logic [KROW_W-1:0] kern_r [KSIZE];
  logic [COL_W-1:0]  wm1_r, wm1_nxt;
  logic [ROW_W-1:0]  hm1_r, hm1_nxt;
  logic [WV_W-1:0]   wv;
  logic [IMG_H_W-1:0] hv;

  always_comb begin
    wv = WV_W'(cfg_data[IMG_W_W-1:0]);
    hv = cfg_data[IMG_H_W-1:0];
    if (wv < WV_W'(3)) begin
      wm1_nxt = COL_W'(2);
    end else if (wv > WV_W'(MAX_WIDTH)) begin
      wm1_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1_nxt = COL_W'(wv - WV_W'(1));
    end
    if (hv < IMG_H_W'(3)) begin
      hm1_nxt = ROW_W'(2);
    end else if (hv > IMG_H_W'(MAX_HEIGHT)) begin
      hm1_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1_nxt = ROW_W'(hv - IMG_H_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0] <= KTOP_RST;
      kern_r[1] <= KMID_RST;
      kern_r[2] <= KBOTTOM_RST;
      wm1_r     <= COL_W'(W_RST - 1);
      hm1_r     <= ROW_W'(IMG_H_RST - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_TOP:    kern_r[0] <= cfg_data[KROW_W-1:0];
        CFG_KERNEL_MID:    kern_r[1] <= cfg_data[KROW_W-1:0];
        CFG_KERNEL_BOTTOM: kern_r[2] <= cfg_data[KROW_W-1:0];
        CFG_IMAGE_WIDTH:   wm1_r <= wm1_nxt;
        CFG_IMAGE_HEIGHT:  hm1_r <= hm1_nxt;
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  logic skid_full_r;
  logic adv;
  logic accept;

  assign adv           = !skid_full_r;
  assign in_chan.ready = adv;
  assign accept        = in_chan.valid && adv;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic             emit_cur;
  pos_t             pos_cur;

  always_comb begin
    col_cur = in_chan.frame_start ? '0 : col_r;
    row_cur = in_chan.frame_start ? '0 : row_r;
    if (col_cur >= wm1_r) begin
      col_nxt = '0;
      row_nxt = (row_cur >= hm1_r) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
    emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
               (row_cur <= hm1_r) && (col_cur <= wm1_r);
    pos_cur.row  = row_cur - ROW_W'(1);
    pos_cur.col  = OCOL_W'(col_cur - COL_W'(1));
    pos_cur.last = (row_cur == hm1_r) && (col_cur == wm1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage a: line buffer read data
  logic             valid_a_r;
  logic             emit_a_r;
  pos_t             pos_a_r;
  pix_t             px_a_r;
  logic [COL_W-1:0] idx_a_r;
  logic             fwd_a_r;
  pix_t             fwd_up_r, fwd_lo_r;
  pix_t             rd_up_r, rd_lo_r;
  pix_t             up_eff, lo_eff;
  pix_t             lb_up_mem [MAX_WIDTH];
  pix_t             lb_lo_mem [MAX_WIDTH];

  // same column written by the item ahead at the read edge: take its write data
  assign up_eff = fwd_a_r ? fwd_up_r : rd_up_r;
  assign lo_eff = fwd_a_r ? fwd_lo_r : rd_lo_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_up_r <= lb_up_mem[col_cur];
      rd_lo_r <= lb_lo_mem[col_cur];
    end
    if (adv && valid_a_r) begin
      lb_up_mem[idx_a_r] <= lo_eff;
      lb_lo_mem[idx_a_r] <= px_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      emit_a_r <= emit_cur;
      pos_a_r  <= pos_cur;
      px_a_r   <= in_chan.pixel;
      idx_a_r  <= col_cur;
      fwd_a_r  <= valid_a_r && (idx_a_r == col_cur);
      fwd_up_r <= lo_eff;
      fwd_lo_r <= px_a_r;
    end
  end

  // stage b: window
  logic valid_b_r;
  pos_t pos_b_r;
  pix_t win_r [KSIZE][KSIZE];

  always_ff @(posedge clk) begin
    if (adv && valid_a_r) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      win_r[0][KSIZE-1] <= up_eff;
      win_r[1][KSIZE-1] <= lo_eff;
      win_r[2][KSIZE-1] <= px_a_r;
    end
    if (adv) begin
      pos_b_r <= pos_a_r;
    end
  end

  // stage c: products
  logic  valid_c_r;
  pos_t  pos_c_r;
  coef_t coef [KSIZE][KSIZE];
  prod_t prod_r [KSIZE][KSIZE];

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        coef[r][c] = kern_r[r][COEF_W*c +: COEF_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE; c++) begin
          prod_r[r][c] <= win_r[r][c] * coef[r][c];
        end
      end
      pos_c_r <= pos_b_r;
    end
  end

  // stage d: row sums
  logic  valid_d_r;
  pos_t  pos_d_r;
  rsum_t rsum_r [KSIZE];
  res_t  res;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < KSIZE; r++) begin
        rsum_r[r] <= RSUM_W'(prod_r[r][0]) + RSUM_W'(prod_r[r][1]) + RSUM_W'(prod_r[r][2]);
      end
      pos_d_r <= pos_c_r;
    end
  end

  assign res.filtered = FILT_W'(rsum_r[0]) + FILT_W'(rsum_r[1]) + FILT_W'(rsum_r[2]);
  assign res.pos      = pos_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else if (adv) begin
      valid_b_r <= valid_a_r && emit_a_r;
      valid_c_r <= valid_b_r;
      valid_d_r <= valid_c_r;
    end
  end

  // output register with one skid entry
  logic out_valid_r;
  res_t out_r;
  res_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= valid_d_r;
      end
    end else if (valid_d_r && !skid_full_r) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_r <= skid_full_r ? skid_r : res;
    end else if (!skid_full_r) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.filtered = out_r.filtered;
  assign out_chan.out_row  = out_r.pos.row;
  assign out_chan.out_col  = out_r.pos.col;
  assign out_chan.last     = out_r.pos.last;

endmodule
